FILE: rtl/core/ndp_pkg.sv
// ----------------------------------------------------------------------------
// ndp_pkg: shared types for the egress dma packetizer
// Item codes, the unpacked input item, the result record and the byte swap.
// ----------------------------------------------------------------------------
package ndp_pkg;

	// item selector carried on the slave-side tuser
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_TICK  = 2'd1,
		OP_SLOT  = 2'd2
	} op_t;

	localparam int unsigned IN_TDATA_W  = 184;
	localparam int unsigned OUT_TDATA_W = 184;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] flow_number;
		logic [15:0] body_length;
		logic [63:0] packet_number;
		logic        stats_flag;
		logic        from_memory;
		logic        queue_mid_packet;
		logic [63:0] memory_word;
	} item_t;

	typedef struct packed {
		logic        flit_valid;
		logic        is_head;
		logic [31:0] head_flow;
		logic [15:0] head_length;
		logic [63:0] body_word;
		logic [63:0] flit_packet;
		logic        flit_stats;
		logic        claim_channel;
		logic        release_channel;
	} result_t;

	// reverse byte order of a 64-bit word
	function automatic logic [63:0] swap_bytes(input logic [63:0] v);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			r[8*i +: 8] = v[8*(7-i) +: 8];
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/noc_egress_dma_packetizer.sv
// ----------------------------------------------------------------------------
// noc_egress_dma_packetizer: egress dma packetizer for a noc node
// Turns start, tick and queue-slot items into head and body flits.
// ----------------------------------------------------------------------------
// pipeline: an input transfer loads the input register, and the engine
// decision is then loaded into the result register that drives m_*; an
// item with a result waits in the input register while that one is full
// throughput: one item per cycle while m_tready does not hold a result back;
// the result register holds a finished flit while the input register takes the next item, so both sides stream
// reset: arst_n clears the pipeline valids, transfer counters, budget and
// flits_per_tick; no transfer is active after reset
module noc_egress_dma_packetizer #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel: flits_per_tick
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [7:0]                        cfg_data,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// flow_number[31:0], body_length[47:32], packet_number[111:48],
	// stats_flag[112], from_memory[113], queue_mid_packet[114],
	// memory_word[178:115], zero pad[183:179]
	input  logic [ndp_pkg::IN_TDATA_W-1:0]    s_tdata,
	// op[1:0]
	input  logic [1:0]                        s_tuser,
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// flit_valid[0], head_flow[32:1], head_length[48:33], body_word[112:49],
	// flit_packet[176:113], flit_stats[177], claim_channel[178], zero pad[183:179]
	output logic [ndp_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// is_head[0]
	output logic                              m_tuser,
	// release_channel: last body flit of the packet
	output logic                              m_tlast
);

	ndp_pkg::item_t   item_s1;
	logic             valid_s1;
	ndp_pkg::result_t res_s2;
	logic             valid_s2;

	ndp_pkg::item_t   in_item;
	ndp_pkg::result_t result;
	logic             has_result;
	logic             advance;
	logic             out_free;

	// the register is always writable; writes must only come while idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	// unpack the input transfer
	always_comb begin
		in_item.op               = s_tuser;
		in_item.flow_number      = s_tdata[31:0];
		in_item.body_length      = s_tdata[47:32];
		in_item.packet_number    = s_tdata[111:48];
		in_item.stats_flag       = s_tdata[112];
		in_item.from_memory      = s_tdata[113];
		in_item.queue_mid_packet = s_tdata[114];
		in_item.memory_word      = s_tdata[178:115];
	end

	// result register can take a new flit when empty or being drained
	assign out_free = !valid_s2 || m_tready;
	// items that give no result (tick, dropped start, idle slot) never wait
	assign advance  = valid_s1 && (!has_result || out_free);
	assign s_tready = !valid_s1 || advance;

	ndp_engine #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.item      (item_s1),
		.commit    (advance),
		.has_result(has_result),
		.result    (result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= in_item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && has_result) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_s2 <= result;
		end
	end

	// pack the result transfer
	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.is_head;
	assign m_tlast  = res_s2.release_channel;
	assign m_tdata  = {5'd0, res_s2.claim_channel, res_s2.flit_stats, res_s2.flit_packet,
		res_s2.body_word, res_s2.head_length, res_s2.head_flow, res_s2.flit_valid};

endmodule

FILE: rtl/core/ndp_engine.sv
// ----------------------------------------------------------------------------
// ndp_engine: transfer state and per-item flit decision
// Holds the transfer context and tick budget, and works out one item's result.
// ----------------------------------------------------------------------------
module ndp_engine #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_data,
	input  ndp_pkg::item_t   item,
	input  logic             commit,
	output logic             has_result,
	output ndp_pkg::result_t result
);

	logic [7:0]             flits_per_tick_q;
	logic [LENGTH_BITS-1:0] flits_left_q;
	logic                   head_sent_q;
	logic [31:0]            cur_flow_q;
	logic [63:0]            cur_packet_q;
	logic                   cur_stats_q;
	logic                   cur_from_memory_q;
	logic [7:0]             budget_used_q;

	logic                   busy;
	logic                   is_start;
	logic                   is_tick;
	logic                   is_slot;
	logic                   budget_spent;
	logic                   send;
	logic [LENGTH_BITS-1:0] left_dec;
	logic [LENGTH_BITS-1:0] len_load;
	logic [31:0]            body_ext;
	logic [31:0]            left_ext;
	logic [31:0]            dec_ext;
	logic [63:0]            raw_word;

	assign busy     = (flits_left_q != '0);
	assign is_start = (item.op == ndp_pkg::OP_START);
	assign is_tick  = (item.op == ndp_pkg::OP_TICK);
	assign is_slot  = (item.op == ndp_pkg::OP_SLOT);

	assign budget_spent = (flits_per_tick_q != 8'd0) && (budget_used_q >= flits_per_tick_q);
	assign send = is_slot && busy && !budget_spent && !(!head_sent_q && item.queue_mid_packet);

	assign left_dec = flits_left_q - LENGTH_BITS'(1);
	assign body_ext = 32'(item.body_length);
	assign len_load = body_ext[LENGTH_BITS-1:0];
	assign left_ext = 32'(flits_left_q);
	assign dec_ext  = 32'(left_dec);
	assign raw_word = cur_from_memory_q ? item.memory_word : {cur_flow_q, dec_ext};

	assign has_result = (is_start && !busy) || send;

	always_comb begin
		result = '0;
		if (is_start) begin
			result.claim_channel = 1'b1;
		end else begin
			result.flit_valid  = 1'b1;
			result.flit_packet = cur_packet_q;
			result.flit_stats  = cur_stats_q;
			if (!head_sent_q) begin
				result.is_head     = 1'b1;
				result.head_flow   = cur_flow_q;
				result.head_length = left_ext[15:0];
			end else begin
				result.body_word       = ndp_pkg::swap_bytes(raw_word);
				result.release_channel = (left_dec == '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flits_per_tick_q <= 8'd0;
		end else if (cfg_we) begin
			flits_per_tick_q <= cfg_data;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flits_left_q  <= '0;
			head_sent_q   <= 1'b0;
			budget_used_q <= 8'd0;
		end else if (commit) begin
			if (is_start && !busy) begin
				flits_left_q <= len_load;
				head_sent_q  <= 1'b0;
			end else if (is_tick) begin
				budget_used_q <= 8'd0;
			end else if (send) begin
				if (!head_sent_q) begin
					head_sent_q <= 1'b1;
				end else begin
					flits_left_q <= left_dec;
				end
				if (budget_used_q != 8'hFF) begin
					budget_used_q <= budget_used_q + 8'd1;
				end
			end
		end
	end

	// transfer context, only read once a start has loaded it
	always_ff @(posedge clk) begin
		if (commit && is_start && !busy) begin
			cur_flow_q        <= item.flow_number;
			cur_packet_q      <= item.packet_number;
			cur_stats_q       <= item.stats_flag;
			cur_from_memory_q <= item.from_memory;
		end
	end

endmodule

FILE: tb/noc_egress_dma_packetizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// noc_egress_dma_packetizer_tb: self-checking bench for the egress packetizer
// A planned list of start, tick and slot items (plus budget writes) is driven
// into the slave stream. An in-bench flit model predicts every claim, head and
// body flit, and the master stream is checked field by field against it.
// ----------------------------------------------------------------------------
module noc_egress_dma_packetizer_tb;

	localparam int unsigned LENGTH_BITS = 16;
	// op code outside the defined set, must be dropped by the block
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// cycles with no input transfer before a budget write (two-stage pipe)
	localparam int unsigned SETTLE_CYCLES = 4;
	// extra cycles at the end to catch stray results
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct {
		bit              is_cfg;
		logic [7:0]      cfg_value;
		ndp_pkg::item_t  item;
		int unsigned     gap;
	} drive_entry_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [7:0]                      cfg_data = '0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	// flow_number, body_length, packet_number, stats_flag, from_memory,
	// queue_mid_packet, memory_word, zero pad
	logic [ndp_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	// op
	logic [1:0]                      s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	// flit_valid, head_flow, head_length, body_word, flit_packet, flit_stats,
	// claim_channel, zero pad
	logic [ndp_pkg::OUT_TDATA_W-1:0] m_tdata;
	// is_head
	logic                            m_tuser;
	// release_channel
	logic                            m_tlast;

	noc_egress_dma_packetizer #(
		.LENGTH_BITS(LENGTH_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------
	// flit model state, a private copy of the transfer engine
	// ------------------------------------------------------------------
	logic [7:0]             limit_per_tick = '0;
	logic [LENGTH_BITS-1:0] body_left = '0;
	logic                   head_done = 1'b0;
	logic [31:0]            tx_flow = '0;
	logic [63:0]            tx_packet = '0;
	logic                   tx_stats = 1'b0;
	logic                   tx_mem = 1'b0;
	logic [7:0]             tick_flits = '0;

	ndp_pkg::result_t egress_due[$];
	drive_entry_t     drive_plan[$];
	int unsigned      error_count = 0;

	// advance the model by one accepted item and queue what it produces
	task automatic packetize_item(input ndp_pkg::item_t it);
		ndp_pkg::result_t r;
		logic [63:0] raw;
		r = '0;
		raw = '0;
		case (it.op)
			ndp_pkg::OP_START: begin
				// a start while body flits are still owed is dropped
				if (body_left == '0) begin
					tx_flow = it.flow_number;
					body_left = it.body_length[LENGTH_BITS-1:0];
					tx_packet = it.packet_number;
					tx_stats = it.stats_flag;
					tx_mem = it.from_memory;
					head_done = 1'b0;
					r.claim_channel = 1'b1;
					egress_due.push_back(r);
				end
			end
			ndp_pkg::OP_TICK: begin
				tick_flits = '0;
			end
			ndp_pkg::OP_SLOT: begin
				// needs flits owed, budget left, and no head into a busy queue tail
				if (body_left != '0 && (limit_per_tick == '0 || tick_flits < limit_per_tick)
						&& (head_done || !it.queue_mid_packet)) begin
					r.flit_valid = 1'b1;
					r.flit_packet = tx_packet;
					r.flit_stats = tx_stats;
					if (!head_done) begin
						r.is_head = 1'b1;
						r.head_flow = tx_flow;
						r.head_length = 16'(body_left);
						head_done = 1'b1;
					end else begin
						body_left = body_left - 1'b1;
						// synthetic word carries the count left after this flit
						raw = tx_mem ? it.memory_word : {tx_flow, 32'(body_left)};
						for (int i = 0; i < 8; i++) begin
							r.body_word[8*i +: 8] = raw[8*(7-i) +: 8];
						end
						r.release_channel = (body_left == '0);
					end
					if (tick_flits != 8'hff) begin
						tick_flits = tick_flits + 1'b1;
					end
					egress_due.push_back(r);
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic compare_field(input string name, input logic [63:0] seen,
			input logic [63:0] wanted);
		if (seen !== wanted) begin
			flag_mismatch($sformatf("%s got %h expected %h", name, seen, wanted));
		end
	endtask

	// ------------------------------------------------------------------
	// driver: one item or one budget write at a time from drive_plan
	// ------------------------------------------------------------------
	int unsigned    gap_left = 0;
	int unsigned    since_item = 0;
	logic           next_s_valid;
	logic           next_cfg_valid;
	ndp_pkg::item_t s_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			cfg_valid <= 1'b0;
			gap_left = 0;
			since_item = 0;
		end else begin
			next_s_valid = s_tvalid;
			next_cfg_valid = cfg_valid;
			if (since_item < SETTLE_CYCLES) begin
				since_item++;
			end
			// input transfer: feed the model in acceptance order
			if (s_tvalid && s_tready) begin
				packetize_item(s_item);
				next_s_valid = 1'b0;
				since_item = 0;
			end
			// budget write transfer
			if (cfg_valid && cfg_ready) begin
				limit_per_tick = cfg_data;
				next_cfg_valid = 1'b0;
			end
			if (!next_s_valid && !next_cfg_valid) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (drive_plan.size() != 0) begin
					if (!drive_plan[0].is_cfg) begin
						s_item = drive_plan[0].item;
						s_tdata <= {5'b0, s_item.memory_word, s_item.queue_mid_packet,
							s_item.from_memory, s_item.stats_flag, s_item.packet_number,
							s_item.body_length, s_item.flow_number};
						s_tuser <= s_item.op;
						next_s_valid = 1'b1;
						gap_left = drive_plan[0].gap;
						drive_plan.delete(0);
					end else if (egress_due.size() == 0 && since_item >= SETTLE_CYCLES) begin
						// write the budget only once the pipe has gone quiet
						cfg_data <= drive_plan[0].cfg_value;
						next_cfg_valid = 1'b1;
						gap_left = drive_plan[0].gap;
						drive_plan.delete(0);
					end
				end
			end
			s_tvalid <= next_s_valid;
			cfg_valid <= next_cfg_valid;
		end
	end

	// ------------------------------------------------------------------
	// monitor: random backpressure, compare each result transfer
	// ------------------------------------------------------------------
	int unsigned      stall_left = 0;
	int unsigned      results_seen = 0;
	bit               calm_sink = 1'b0;
	ndp_pkg::result_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (egress_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected result tdata %h", m_tdata));
				end else begin
					want = egress_due.pop_front();
					compare_field("flit_valid", 64'(m_tdata[0]), 64'(want.flit_valid));
					compare_field("is_head", 64'(m_tuser), 64'(want.is_head));
					compare_field("head_flow", 64'(m_tdata[32:1]), 64'(want.head_flow));
					compare_field("head_length", 64'(m_tdata[48:33]),
						64'(want.head_length));
					compare_field("body_word", m_tdata[112:49], want.body_word);
					compare_field("flit_packet", m_tdata[176:113], want.flit_packet);
					compare_field("flit_stats", 64'(m_tdata[177]), 64'(want.flit_stats));
					compare_field("claim_channel", 64'(m_tdata[178]),
						64'(want.claim_channel));
					compare_field("release_channel", 64'(m_tlast),
						64'(want.release_channel));
				end
				results_seen++;
				// now and then a stretch with no stalls at all
				if (results_seen % 32 == 0) begin
					calm_sink = ($urandom_range(0, 3) == 0);
				end
				stall_left = calm_sink ? 0 : $urandom_range(0, 10);
			end
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus planning
	// ------------------------------------------------------------------
	bit          calm_source = 1'b0;
	int unsigned planned = 0;

	// every field random; start lengths kept short unless overridden
	function automatic ndp_pkg::item_t any_item(input logic [1:0] op);
		ndp_pkg::item_t it;
		it.op = op;
		it.flow_number = $urandom;
		it.body_length = 16'($urandom_range(0, 15));
		it.packet_number = {$urandom, $urandom};
		it.stats_flag = 1'($urandom_range(0, 1));
		it.from_memory = 1'($urandom_range(0, 1));
		it.queue_mid_packet = ($urandom_range(0, 3) == 0);
		it.memory_word = {$urandom, $urandom};
		return it;
	endfunction

	task automatic plan_item(input ndp_pkg::item_t it);
		drive_entry_t e;
		planned++;
		if (planned % 40 == 0) begin
			calm_source = ($urandom_range(0, 3) == 0);
		end
		e.is_cfg = 1'b0;
		e.cfg_value = '0;
		e.item = it;
		e.gap = calm_source ? 0 : $urandom_range(0, 10);
		drive_plan.push_back(e);
	endtask

	task automatic plan_cfg(input logic [7:0] v);
		drive_entry_t e;
		e.is_cfg = 1'b1;
		e.cfg_value = v;
		e.item = '0;
		e.gap = $urandom_range(0, 10);
		drive_plan.push_back(e);
	endtask

	// packets: a start followed by slots, with ticks and noise mixed in
	task automatic plan_traffic(input int unsigned quota);
		int unsigned sent;
		int unsigned len;
		int unsigned roll;
		int unsigned reach;
		ndp_pkg::item_t it;
		sent = 0;
		while (sent < quota) begin
			roll = $urandom_range(0, 99);
			len = roll < 70 ? $urandom_range(0, 6) :
				roll < 95 ? $urandom_range(7, 40) : $urandom_range(41, 160);
			it = any_item(ndp_pkg::OP_START);
			it.body_length = 16'(len);
			plan_item(it);
			sent++;
			reach = len + 2 + $urandom_range(0, 4);
			for (int k = 0; k < reach; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 15) begin
					plan_item(any_item(ndp_pkg::OP_TICK));
				end else if (roll < 19) begin
					plan_item(any_item(OP_UNUSED));
				end else if (roll < 23) begin
					plan_item(any_item(ndp_pkg::OP_START));
				end else begin
					plan_item(any_item(ndp_pkg::OP_SLOT));
				end
				// dropped op codes do not count toward the quota
				if (roll < 15 || roll >= 19) begin
					sent++;
				end
			end
		end
	endtask

	initial begin
		ndp_pkg::item_t it;
		logic [7:0] phase_limit[8];

		// --- directed: unlimited budget, synthetic body of three flits
		plan_cfg(8'd0);
		it = any_item(ndp_pkg::OP_START);
		it.flow_number = '1;
		it.body_length = 16'd3;
		it.packet_number = '1;
		it.stats_flag = 1'b1;
		it.from_memory = 1'b0;
		plan_item(it);
		// head held back while the queue tail is inside another packet
		it = any_item(ndp_pkg::OP_SLOT);
		it.queue_mid_packet = 1'b1;
		plan_item(it);
		it.queue_mid_packet = 1'b0;
		plan_item(it);
		// start while busy, dropped
		it = any_item(ndp_pkg::OP_START);
		it.body_length = '1;
		plan_item(it);
		// body flits ignore the mid-packet flag
		it = any_item(ndp_pkg::OP_SLOT);
		it.queue_mid_packet = 1'b1;
		plan_item(it);
		plan_item(any_item(OP_UNUSED));
		plan_item(any_item(ndp_pkg::OP_SLOT));
		plan_item(any_item(ndp_pkg::OP_SLOT));
		// nothing owed any more
		plan_item(any_item(ndp_pkg::OP_SLOT));
		// zero length start: claim only, never a flit
		it = any_item(ndp_pkg::OP_START);
		it.flow_number = '0;
		it.body_length = '0;
		it.packet_number = '0;
		it.stats_flag = 1'b0;
		plan_item(it);
		it = any_item(ndp_pkg::OP_SLOT);
		it.queue_mid_packet = 1'b0;
		plan_item(it);
		// body words from memory
		it = any_item(ndp_pkg::OP_START);
		it.body_length = 16'd2;
		it.from_memory = 1'b1;
		plan_item(it);
		it = any_item(ndp_pkg::OP_SLOT);
		it.queue_mid_packet = 1'b0;
		it.memory_word = '0;
		plan_item(it);
		it.memory_word = 64'h0123_4567_89ab_cdef;
		plan_item(it);
		it.memory_word = '1;
		plan_item(it);

		// --- directed: one flit per tick
		plan_cfg(8'd1);
		plan_item(any_item(ndp_pkg::OP_TICK));
		it = any_item(ndp_pkg::OP_START);
		it.body_length = 16'd2;
		plan_item(it);
		it = any_item(ndp_pkg::OP_SLOT);
		it.queue_mid_packet = 1'b0;
		plan_item(it);
		// budget spent
		plan_item(it);
		plan_item(any_item(ndp_pkg::OP_TICK));
		plan_item(it);
		plan_item(any_item(ndp_pkg::OP_TICK));
		plan_item(it);

		// --- random packet traffic over a range of budgets
		phase_limit[0] = 8'hff;
		phase_limit[1] = 8'd1;
		phase_limit[2] = 8'd2;
		phase_limit[3] = 8'd0;
		phase_limit[4] = 8'd3;
		phase_limit[5] = 8'($urandom);
		phase_limit[6] = 8'($urandom_range(1, 8));
		phase_limit[7] = 8'd0;
		for (int p = 0; p < 8; p++) begin
			plan_cfg(phase_limit[p]);
			plan_traffic(60);
		end

		// --- longest body: drain whatever is open, then a full-length start
		plan_cfg(8'd0);
		for (int k = 0; k < 170; k++) begin
			it = any_item(ndp_pkg::OP_SLOT);
			it.queue_mid_packet = 1'b0;
			plan_item(it);
		end
		plan_cfg(8'($urandom_range(4, 254)));
		it = any_item(ndp_pkg::OP_START);
		it.body_length = '1;
		it.from_memory = 1'b0;
		plan_item(it);
		for (int k = 0; k < 16; k++) begin
			it = any_item(($urandom_range(0, 4) == 0) ? ndp_pkg::OP_TICK : ndp_pkg::OP_SLOT);
			it.queue_mid_packet = 1'b0;
			plan_item(it);
		end

		// single reset at the start, released away from the clock edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (drive_plan.size() != 0 || s_tvalid || cfg_valid || egress_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule
